// ===== rtl/core/tea_pkg.sv =====
// Shared types and constants for the triangle edge adjacency block.
`timescale 1ns / 1ps

package tea_pkg;

  localparam int TBL_AW        = 13;
  localparam int TABLE_ENTRIES = 1 << TBL_AW;
  localparam int MAX_TRIANGLES = 4096;
  localparam int PROBE_LIMIT   = 16;
  localparam int PRB_W         = $clog2(PROBE_LIMIT + 1);

  localparam int TRI_W  = 12;
  localparam int SLOT_W = 2;
  localparam int VTX_W  = 16;
  localparam int KEY_W  = 2 * VTX_W;
  localparam int RNG_W  = 17;  // wide enough to compare against MAX_TRIANGLES

  localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B1;
  localparam int               HASH_LSB  = 16;

  localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd3;

  localparam logic ACT_EDGE    = 1'b0;
  localparam logic ACT_CLEAR   = 1'b1;
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_FULL   = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FIRST,
    S_CHECK
  } seq_state_t;

  // Input edge, last field in the lowest bits.
  typedef struct packed {
    logic [VTX_W-1:0]  vb;
    logic [VTX_W-1:0]  va;
    logic [SLOT_W-1:0] slot;
    logic [TRI_W-1:0]  tri_idx;
  } edge_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TRI_W-1:0]  owner_tri;
    logic [SLOT_W-1:0] owner_slot;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [TBL_AW-1:0] addr;
    entry_t            wdata;
  } tbl_req_t;

  typedef struct packed {
    logic              kind;
    logic              last;
    logic [TRI_W-1:0]  ntri;
    logic [SLOT_W-1:0] tslot;
    logic [TRI_W-1:0]  ttri;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_load_t;

endpackage

// ===== rtl/core/tea_table.sv =====
// Single-port entry memory of the edge hash table, registered read.
`timescale 1ns / 1ps

module tea_table (
  input  logic              clk,
  input  tea_pkg::tbl_req_t req,
  output tea_pkg::entry_t   rd_data
);
  import tea_pkg::*;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/tea_seq.sv =====
// Probe sequencer: key ordering, hash, linear probe loop and table sweep.
`timescale 1ns / 1ps

module tea_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  tea_pkg::edge_t     in_edge,
  input  logic               q_empty,
  output tea_pkg::res_load_t ld,
  output tea_pkg::tbl_req_t  req,
  input  tea_pkg::entry_t    rd_data
);
  import tea_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [TBL_AW-1:0] addr_r, addr_nxt;
  logic [PRB_W-1:0]  probe_r, probe_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TRI_W-1:0]  tri_r, tri_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [KEY_W-1:0]  prod;
  logic [KEY_W-1:0]  ord_key;
  logic              first_ok, second_ok;
  res_t              res_a, res_b, res_full;

  assign prod    = key_r * HASH_MULT;
  assign ord_key = (in_edge.va < in_edge.vb) ? {in_edge.va, in_edge.vb}
                                             : {in_edge.vb, in_edge.va};

  assign first_ok  = (slot_r != SLOT_NONE);
  assign second_ok = (rd_data.owner_slot != SLOT_NONE);

  always_comb begin
    res_a       = '0;
    res_a.kind  = KIND_UPDATE;
    res_a.last  = !second_ok;
    res_a.ttri  = tri_r;
    res_a.tslot = slot_r;
    res_a.ntri  = rd_data.owner_tri;

    res_b       = '0;
    res_b.kind  = KIND_UPDATE;
    res_b.last  = 1'b1;
    res_b.ttri  = rd_data.owner_tri;
    res_b.tslot = rd_data.owner_slot;
    res_b.ntri  = tri_r;

    res_full       = '0;
    res_full.kind  = KIND_FULL;
    res_full.last  = 1'b1;
    res_full.ttri  = tri_r;
    res_full.tslot = slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      probe_r <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      probe_r <= probe_nxt;
    end
    key_r  <= key_nxt;
    tri_r  <= tri_nxt;
    slot_r <= slot_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    probe_nxt = probe_r;
    key_nxt   = key_r;
    tri_nxt   = tri_r;
    slot_nxt  = slot_r;
    in_ready  = 1'b0;
    ld        = '0;
    req       = '0;
    req.addr  = addr_r;

    unique case (state_r)
      S_CLEAR: begin
        req.wr_en = 1'b1;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == {TBL_AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt  = ord_key;
          tri_nxt  = in_edge.tri_idx;
          slot_nxt = in_edge.slot;
          if (in_action == ACT_CLEAR) begin
            addr_nxt  = '0;
            state_nxt = S_CLEAR;
          end else if (RNG_W'(in_edge.tri_idx) < RNG_W'(MAX_TRIANGLES)) begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        addr_nxt  = prod[HASH_LSB +: TBL_AW];
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        req.rd_en = 1'b1;
        probe_nxt = '0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!rd_data.valid) begin
          // free entry: claim it for this edge
          req.wr_en            = 1'b1;
          req.wdata.valid      = 1'b1;
          req.wdata.key        = key_r;
          req.wdata.owner_tri  = tri_r;
          req.wdata.owner_slot = slot_r;
          state_nxt            = S_IDLE;
        end else if (rd_data.key == key_r) begin
          if (!first_ok && !second_ok) begin
            state_nxt = S_IDLE;
          end else if (q_empty) begin
            ld.n      = 2'(first_ok) + 2'(second_ok);
            ld.r0     = first_ok ? res_a : res_b;
            ld.r1     = res_b;
            state_nxt = S_IDLE;
          end
        end else if (probe_r == PRB_W'(PROBE_LIMIT - 1)) begin
          if (q_empty) begin
            ld.n      = 2'd1;
            ld.r0     = res_full;
            state_nxt = S_IDLE;
          end
        end else begin
          // collision: read the next entry in the same cycle
          addr_nxt  = addr_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          req.rd_en = 1'b1;
          req.addr  = addr_r + 1'b1;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ===== rtl/core/tea_outq.sv =====
// Two-entry result queue feeding the output channel.
`timescale 1ns / 1ps

module tea_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  tea_pkg::res_load_t ld,
  output logic               q_empty,
  output logic               out_valid,
  input  logic               out_ready,
  output tea_pkg::res_t      out_res
);
  import tea_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  res_t       q0_r, q0_nxt;
  res_t       q1_r, q1_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  // loads arrive only while empty, so load and pop never coincide
  always_comb begin
    cnt_nxt = cnt_r;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    if (ld.n != 2'd0) begin
      cnt_nxt = ld.n;
      q0_nxt  = ld.r0;
      q1_nxt  = ld.r1;
    end else if (out_valid && out_ready) begin
      cnt_nxt = cnt_r - 1'b1;
      q0_nxt  = q1_r;
    end
  end

  assign q_empty   = (cnt_r == 2'd0);
  assign out_valid = !q_empty;
  assign out_res   = q0_r;

endmodule

// ===== rtl/core/triangle_edge_adjacency_top.sv =====
// Top level of the triangle edge adjacency hash table.
`timescale 1ns / 1ps

// Registers triangle edges in an 8192-entry open-addressed table keyed by the
// ordered vertex pair, with linear probing over up to 16 entries. A new edge
// is stored silently; an edge that matches a stored one returns up to two
// neighbor updates (new triangle first, then the stored owner), and an edge
// whose probes all collide returns one table-full transfer and is dropped.
// The block handles one edge at a time and holds in_tready low while it
// works. The single-port table memory with registered read sets its steps:
// the hash multiply, the first read, then one compare-and-next-read per
// probe. Up to two results wait in an output queue, so the next edge is
// taken while they drain; an edge that produces results waits only if the
// queue still holds earlier ones. After reset, and on each clear action, a
// sweep writes every table entry invalid, one per cycle, with in_tready low.
// Clear and out-of-range triangles give no transfer.

module triangle_edge_adjacency_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // tri_index[11:0], edge_slot[13:12],
                                  // vertex_a[29:14], vertex_b[45:30], zero pad
  input  logic        in_tuser,   // action (0 register edge, 1 clear)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // target_tri[11:0], target_slot[13:12],
                                  // neighbor_tri[25:14], zero pad
  output logic        out_tuser,  // kind (0 neighbor update, 1 table full)
  output logic        out_tlast   // last transfer for this edge
);
  import tea_pkg::*;

  edge_t     in_edge;
  tbl_req_t  req;
  entry_t    rd_data;
  res_load_t ld;
  res_t      out_res;
  logic      q_empty;

  assign in_edge = edge_t'(in_tdata[$bits(edge_t)-1:0]);

  tea_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_action(in_tuser),
    .in_edge  (in_edge),
    .q_empty  (q_empty),
    .ld       (ld),
    .req      (req),
    .rd_data  (rd_data)
  );

  tea_table u_table (
    .clk    (clk),
    .req    (req),
    .rd_data(rd_data)
  );

  tea_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld),
    .q_empty  (q_empty),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {6'b0, out_res.ntri, out_res.tslot, out_res.ttri};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

// ===== rtl/core/tea_checker.sv =====
// Port-level checks for the triangle edge adjacency top level.
`timescale 1ns / 1ps

module tea_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // reset starts the table sweep, so no edge is taken right after it
  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("in_tready high right after reset");

  // an accepted transfer always leaves the block busy right after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an accepted transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                 && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output transfer changed");

  // table-full is a single last transfer with no neighbor
  a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[25:14] == 12'd0))
    else $error("malformed table-full transfer");

  // neighbor updates never target edge slot three
  a_update_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[13:12] != 2'd3)
    else $error("neighbor update targets slot three");

endmodule

bind triangle_edge_adjacency_top tea_checker u_tea_checker (.*);

// ===== tb/tb_triangle_edge_adjacency_top.sv =====
// Self-checking testbench for the triangle edge adjacency hash table.
`timescale 1ns / 1ps

// Drives edge registrations and clears into the block. Each accepted transfer
// updates a local copy of the hash table, and the neighbor updates or
// table-full results that it implies are queued. Every output transfer is
// compared field by field with the oldest queued result.
//
// Directed part: a short table of edges, most with hand-written results,
// covering vertex and triangle extremes, degenerate edges, swapped vertex
// order and edge slot three on either side of a hit. Then one crowd of keys
// that all hash to a home entry near the top of the table is sent, so probing
// wraps past the last entry and the final key finds the table full.
//
// Random part: mostly edges that are registered and later met again from
// another triangle, so hits dominate. The rest is fresh edges, degenerate
// edges, clears and further crowds of colliding keys.
//
// The sender runs in bursts with random gaps. The receiver switches between
// always ready, coin flip and sparse ready. Once it holds off for a long
// stretch so the block backs up into its input. The sender sometimes waits
// until every queued result has arrived.

module tb_triangle_edge_adjacency_top;
  import tea_pkg::*;

  localparam int ITEM_TARGET     = 1450;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SETTLE_CYCLES   = 40;    // a bit over two worst-case edges
  localparam int DRAIN_LIMIT     = 5000;
  localparam int KNOWN_DEPTH     = 48;
  localparam int FLOOD_BUDGET    = 4;
  // Sweeps after reset and on each clear dominate the run.
  localparam int TIMEOUT_NS      = 30_000_000;

  typedef struct packed {
    logic              action;
    logic [TRI_W-1:0]  tri_idx;
    logic [SLOT_W-1:0] slot;
    logic [VTX_W-1:0]  va;
    logic [VTX_W-1:0]  vb;
  } edge_req_t;

  typedef struct packed {
    logic              kind;
    logic [TRI_W-1:0]  target_tri;
    logic [SLOT_W-1:0] target_slot;
    logic [TRI_W-1:0]  neighbor_tri;
    logic              is_last;
  } adj_result_t;

  // One row of the directed table. When typed is set, the results written in
  // the row are queued instead of the local table's answer.
  typedef struct packed {
    edge_req_t   req;
    logic        typed;
    logic [1:0]  n_typed;
    adj_result_t res_a;
    adj_result_t res_b;
  } plan_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_t;

  localparam adj_result_t NO_RESULT = '0;

  localparam plan_row_t DIRECTED_PLAN [11] = '{
    // clear with every other field at its maximum: no result
    '{'{ACT_CLEAR, 12'hFFF, 2'd3, 16'hFFFF, 16'hFFFF}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    // degenerate edge at vertex zero, first sighting: stored silently
    '{'{ACT_EDGE, 12'd0, 2'd0, 16'h0000, 16'h0000}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    // same edge from the top triangle: both sides told
    '{'{ACT_EDGE, 12'd4095, 2'd2, 16'h0000, 16'h0000}, 1'b1, 2'd2,
      '{KIND_UPDATE, 12'd4095, 2'd2, 12'd0, 1'b0},
      '{KIND_UPDATE, 12'd0, 2'd0, 12'd4095, 1'b1}},
    '{'{ACT_EDGE, 12'd1, 2'd1, 16'hFFFF, 16'h0000}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    // vertex order swapped still matches
    '{'{ACT_EDGE, 12'd2, 2'd2, 16'h0000, 16'hFFFF}, 1'b1, 2'd2,
      '{KIND_UPDATE, 12'd2, 2'd2, 12'd1, 1'b0},
      '{KIND_UPDATE, 12'd1, 2'd1, 12'd2, 1'b1}},
    // owner stored with slot three
    '{'{ACT_EDGE, 12'd100, 2'd3, 16'hFFFF, 16'hFFFF}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    // stored owner has slot three: only the new triangle is told
    '{'{ACT_EDGE, 12'd200, 2'd1, 16'hFFFF, 16'hFFFF}, 1'b1, 2'd1,
      '{KIND_UPDATE, 12'd200, 2'd1, 12'd100, 1'b1}, NO_RESULT},
    // slot three on both sides: hit with nothing to report
    '{'{ACT_EDGE, 12'd300, 2'd3, 16'hFFFF, 16'hFFFF}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    // new triangle has slot three: only the stored owner is told
    '{'{ACT_EDGE, 12'd4095, 2'd3, 16'h0000, 16'h0000}, 1'b1, 2'd1,
      '{KIND_UPDATE, 12'd0, 2'd0, 12'd4095, 1'b1}, NO_RESULT},
    // alternating bit patterns, checked against the local table
    '{'{ACT_EDGE, 12'hAAA, 2'd1, 16'h5555, 16'hAAAA}, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{'{ACT_EDGE, 12'h555, 2'd2, 16'hAAAA, 16'h5555}, 1'b0, 2'd0, NO_RESULT, NO_RESULT}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Local copy of the hash table.
  bit                tbl_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0]  tbl_key   [TABLE_ENTRIES];
  logic [TRI_W-1:0]  tbl_tri   [TABLE_ENTRIES];
  logic [SLOT_W-1:0] tbl_slot  [TABLE_ENTRIES];

  adj_result_t            pending_results[$];
  logic [2*VTX_W-1:0]     known_pairs[$];   // {va, vb} of edges seen lately
  adj_result_t            due;
  int                     error_count;
  int                     edges_sent;
  int                     burst_left;
  bit                     hold_off_req;

  triangle_edge_adjacency_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- hashing

  function automatic logic [KEY_W-1:0] edge_key(input logic [VTX_W-1:0] va,
                                                input logic [VTX_W-1:0] vb);
    return (va < vb) ? {va, vb} : {vb, va};
  endfunction

  // Multiplicative hash: bits 28..16 of the 32-bit product.
  function automatic logic [TBL_AW-1:0] home_slot_of(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] prod;
    prod = key * HASH_MULT;
    return prod[HASH_LSB +: TBL_AW];
  endfunction

  // Applies one accepted transfer to the local table and returns the results
  // that it causes, in output order.
  task automatic predict_adjacency(input edge_req_t req, output int n_res,
                                   output adj_result_t res0, output adj_result_t res1);
    logic [KEY_W-1:0]  key;
    logic [TBL_AW-1:0] idx;
    logic [TRI_W-1:0]  otri;
    logic [SLOT_W-1:0] oslot;
    adj_result_t       upd;
    bit                tell_new;
    bit                tell_owner;
    bit                settled;
    n_res   = 0;
    res0    = NO_RESULT;
    res1    = NO_RESULT;
    settled = 1'b0;
    if (req.action == ACT_CLEAR) begin
      foreach (tbl_valid[j]) tbl_valid[j] = 1'b0;
    end else if (req.tri_idx < MAX_TRIANGLES) begin
      key = edge_key(req.va, req.vb);
      idx = home_slot_of(key);
      for (int p = 0; p < PROBE_LIMIT && !settled; p++) begin
        if (!tbl_valid[idx]) begin
          // miss: claim the free entry
          tbl_valid[idx] = 1'b1;
          tbl_key[idx]   = key;
          tbl_tri[idx]   = req.tri_idx;
          tbl_slot[idx]  = req.slot;
          settled        = 1'b1;
        end else if (tbl_key[idx] == key) begin
          otri       = tbl_tri[idx];
          oslot      = tbl_slot[idx];
          tell_new   = (req.slot != SLOT_NONE);
          tell_owner = (oslot != SLOT_NONE);
          if (tell_new) begin
            res0  = '{KIND_UPDATE, req.tri_idx, req.slot, otri, !tell_owner};
            n_res = 1;
          end
          if (tell_owner) begin
            upd = '{KIND_UPDATE, otri, oslot, req.tri_idx, 1'b1};
            if (n_res == 0) res0 = upd;
            else res1 = upd;
            n_res++;
          end
          settled = 1'b1;
        end else begin
          idx = idx + 1'b1;  // wraps at the table end
        end
      end
      if (!settled) begin
        res0  = '{KIND_FULL, req.tri_idx, req.slot, {TRI_W{1'b0}}, 1'b1};
        n_res = 1;
      end
    end
  endtask

  // ---------------------------------------------------------------- sender

  // Offers one transfer; valid stays up across a burst and drops after it.
  task automatic send_edge(input edge_req_t req, input logic typed,
                           input logic [1:0] n_typed, input adj_result_t t0,
                           input adj_result_t t1);
    int          n_pred;
    int          gap;
    adj_result_t p0;
    adj_result_t p1;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_tdata  <= {2'b00, req.vb, req.va, req.slot, req.tri_idx};
    in_tuser  <= req.action;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_adjacency(req, n_pred, p0, p1);
    if (typed) begin
      n_pred = n_typed;
      p0     = t0;
      p1     = t1;
    end
    if (n_pred > 0) pending_results.insert(pending_results.size(), p0);
    if (n_pred > 1) pending_results.insert(pending_results.size(), p1);
    edges_sent++;
    burst_left--;
    @(negedge clk);
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  // Valid is high exactly when a burst is open and not yet lowered.
  task automatic stop_offering();
    if (burst_left != 0) in_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic drain_pause();
    stop_offering();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic remember_pair(input logic [VTX_W-1:0] va, input logic [VTX_W-1:0] vb);
    known_pairs.insert(known_pairs.size(), {va, vb});
    if (known_pairs.size() > KNOWN_DEPTH) void'(known_pairs.pop_front());
  endtask

  function automatic logic [VTX_W-1:0] pick_vertex();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return VTX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [TRI_W-1:0] pick_tri();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return TRI_W'(MAX_TRIANGLES - 1);
      default: return TRI_W'($urandom_range(0, MAX_TRIANGLES - 1));
    endcase
  endfunction

  // Sends count distinct-looking keys that all hash to one home entry, so the
  // probe window fills and later keys come back as table full.
  task automatic flood_home_slot(input logic [TBL_AW-1:0] home, input int count);
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
    edge_req_t        req;
    int               found;
    found = 0;
    while (found < count) begin
      va = VTX_W'($urandom);
      vb = VTX_W'($urandom);
      if (home_slot_of(edge_key(va, vb)) == home) begin
        req = '{ACT_EDGE, pick_tri(), SLOT_W'($urandom_range(0, 3)), va, vb};
        send_edge(req, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
        remember_pair(va, vb);
        found++;
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // Ready pattern changes at random intervals; one long hold-off is
  // taken once the random part asks for it.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    bit       hold_done;
    out_tready = 1'b0;
    mode_left  = 0;
    hold_done  = 1'b0;
    mode       = RX_OPEN;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          default:   out_tready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: tuser=%0b tdata=0x%0h tlast=%0b",
               out_tuser, out_tdata, out_tlast);
        error_count++;
      end else begin
        due = pending_results.pop_front();
        check_field("kind", due.kind, out_tuser);
        check_field("target_tri", due.target_tri, out_tdata[11:0]);
        check_field("target_slot", due.target_slot, out_tdata[13:12]);
        check_field("neighbor_tri", due.neighbor_tri, out_tdata[25:14]);
        check_field("tdata_pad", 0, out_tdata[31:26]);
        check_field("last", due.is_last, out_tlast);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    edge_req_t          req;
    logic [2*VTX_W-1:0] pair;
    int                 pick;
    int                 floods_left;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    error_count  = 0;
    edges_sent   = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    floods_left  = FLOOD_BUDGET;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_PLAN[r]) begin
      send_edge(DIRECTED_PLAN[r].req, DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].n_typed,
                DIRECTED_PLAN[r].res_a, DIRECTED_PLAN[r].res_b);
    end
    // Home six entries below the top entry: the probe window wraps to entry 8,
    // and the last key of the crowd finds every probe taken.
    flood_home_slot(TBL_AW'(TABLE_ENTRIES - 7), PROBE_LIMIT + 1);
    drain_pause();

    hold_off_req = 1'b1;
    while (edges_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 199);
      if (pick < 2) begin
        req = '{ACT_CLEAR, TRI_W'($urandom), SLOT_W'($urandom), VTX_W'($urandom),
                VTX_W'($urandom)};
        send_edge(req, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
        known_pairs.delete();
      end else if (pick < 4 && floods_left > 0) begin
        flood_home_slot(TBL_AW'($urandom), PROBE_LIMIT + $urandom_range(1, 3));
        floods_left--;
      end else if (pick < 8) begin
        drain_pause();
      end else if (pick < 110 && known_pairs.size() != 0) begin
        // meet a stored edge again, in either vertex order
        pair = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
        req  = '{ACT_EDGE, pick_tri(), SLOT_W'($urandom_range(0, 3)), pair[31:16],
                 pair[15:0]};
        if ($urandom_range(0, 1)) {req.va, req.vb} = {req.vb, req.va};
        send_edge(req, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
      end else if (pick < 122) begin
        req    = '{ACT_EDGE, pick_tri(), SLOT_W'($urandom_range(0, 3)), pick_vertex(),
                   VTX_W'(0)};
        req.vb = req.va;
        send_edge(req, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
        remember_pair(req.va, req.vb);
      end else begin
        req = '{ACT_EDGE, pick_tri(), SLOT_W'($urandom_range(0, 3)), pick_vertex(),
                pick_vertex()};
        send_edge(req, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
        remember_pair(req.va, req.vb);
      end
    end

    stop_offering();
    for (int w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
